// ===== hdl/lrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrd_pkg
// Shared widths, defaults, register indexes and types of the linear
// resampler with stereo downmix.
// ----------------------------------------------------------------------------
package lrd_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEN_IN_W   = 13;
  localparam int unsigned STEP_W     = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;

  localparam int unsigned MAX_BLOCK_FRAMES_DEF = 4096;
  localparam int unsigned PHASE_FRAC_BITS_DEF  = 16;
  localparam int unsigned OUT_CAP              = 32;

  localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_RESAMPLE_EN = 2'd1,
    CFG_STEREO_MODE = 2'd2
  } cfg_idx_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic valid;
    logic last;
  } issue_t;

endpackage

// ===== hdl/lrd_in_if.sv =====
// ----------------------------------------------------------------------------
// lrd_in_if
// Input frame channel: one stereo or mono frame and its block length.
// ----------------------------------------------------------------------------
interface lrd_in_if;
  logic                          valid;
  logic                          ready;
  lrd_pkg::sample_t              left_sample;
  lrd_pkg::sample_t              right_sample;
  logic [lrd_pkg::LEN_IN_W-1:0]  block_length;

  modport source (output valid, left_sample, right_sample, block_length, input ready);
  modport sink   (input valid, left_sample, right_sample, block_length, output ready);
endinterface

// ===== hdl/lrd_out_if.sv =====
// ----------------------------------------------------------------------------
// lrd_out_if
// Output sample channel: one mono sample and the end-of-run flag.
// ----------------------------------------------------------------------------
interface lrd_out_if;
  logic             valid;
  logic             ready;
  lrd_pkg::sample_t out_sample;
  logic             last_of_run;

  modport source (output valid, out_sample, last_of_run, input ready);
  modport sink   (input valid, out_sample, last_of_run, output ready);
endinterface

// ===== hdl/lrd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrd_ctrl
// Position sequencer: takes a frame, walks the output positions that fall
// on it and issues the lanes one interpolation request per unstalled cycle.
// ----------------------------------------------------------------------------
module lrd_ctrl #(
  parameter int unsigned MAX_BLOCK_FRAMES = lrd_pkg::MAX_BLOCK_FRAMES_DEF,
  parameter int unsigned PHASE_FRAC_BITS  = lrd_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lrd_in_if.sink                        in_ch,
  input  logic                          adv_i,
  input  logic [lrd_pkg::STEP_W-1:0]    step_i,
  input  logic                          resample_en_i,
  output lrd_pkg::issue_t               issue_o,
  output lrd_pkg::sample_t              l_a_o,
  output lrd_pkg::sample_t              l_b_o,
  output lrd_pkg::sample_t              r_a_o,
  output lrd_pkg::sample_t              r_b_o,
  output logic [PHASE_FRAC_BITS-1:0]    frac_o
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCK_FRAMES);
  localparam int unsigned LEN_W = IDX_W + 1;
  localparam int unsigned POS_W = LEN_W + PHASE_FRAC_BITS;
  localparam int unsigned SUM_W = ((POS_W > lrd_pkg::STEP_W) ? POS_W : lrd_pkg::STEP_W) + 2;
  localparam int unsigned CMP_W = (LEN_W > lrd_pkg::LEN_IN_W) ? LEN_W : lrd_pkg::LEN_IN_W;
  localparam int unsigned CNT_W = $clog2(lrd_pkg::OUT_CAP + 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  state_e               state_q;
  logic                 pass_q;
  logic                 last_blk_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [IDX_W-1:0]     frame_idx_q;
  logic [IDX_W-1:0]     cur_q;
  logic [POS_W-1:0]     opos_q;
  logic [POS_W-1:0]     pos_q;
  logic [SUM_W-1:0]     sum_q;
  logic [LEN_W-1:0]     len_q;
  lrd_pkg::sample_t     l_q, r_q, prev_l_q, prev_r_q;

  logic [lrd_pkg::STEP_W-1:0] smin, step_eff;
  logic [SUM_W-1:0]     step_s, sum2, limit_s, start_sum;
  logic [CMP_W-1:0]     len_x;
  logic [LEN_W-1:0]     len_eff;
  logic [POS_W-1:0]     top, base, limit, start_pos, frac_full;
  logic                 accept, interp, interp2, emit, emit2, step_now, finish;

  assign smin     = lrd_pkg::STEP_W'(1) << (PHASE_FRAC_BITS - 4);
  assign step_eff = (step_i < smin) ? smin : step_i;
  assign step_s   = SUM_W'(step_eff);

  always_comb begin
    len_x = CMP_W'(in_ch.block_length);
    if (len_x == '0) begin
      len_x = CMP_W'(1);
    end else if (len_x > CMP_W'(MAX_BLOCK_FRAMES)) begin
      len_x = CMP_W'(MAX_BLOCK_FRAMES);
    end
    len_eff = LEN_W'(len_x);
  end

  assign in_ch.ready = (state_q == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  assign start_pos = (frame_idx_q == '0) ? '0 : opos_q;
  assign start_sum = SUM_W'(start_pos) + step_s;

  assign top     = POS_W'(cur_q) << PHASE_FRAC_BITS;
  assign base    = POS_W'(cur_q - IDX_W'(1)) << PHASE_FRAC_BITS;
  assign limit   = POS_W'(len_q) << PHASE_FRAC_BITS;
  assign limit_s = SUM_W'(limit);
  assign sum2    = sum_q + step_s;

  assign interp  = (cur_q != '0) && (pos_q < top);
  assign interp2 = (cur_q != '0) && (sum_q < SUM_W'(top));
  assign emit    = (cnt_q < CNT_W'(lrd_pkg::OUT_CAP)) && (sum_q <= limit_s)
                   && (interp || last_blk_q);
  assign emit2   = ((cnt_q + CNT_W'(1)) < CNT_W'(lrd_pkg::OUT_CAP)) && (sum2 <= limit_s)
                   && (interp2 || last_blk_q);

  assign step_now = (state_q == ST_RUN) && adv_i;
  assign finish   = step_now && (pass_q || !emit || !emit2);

  assign frac_full = (pos_q >= base) ? (pos_q - base) : '0;

  assign issue_o.valid = step_now && (pass_q || emit);
  assign issue_o.last  = pass_q || !emit2;

  always_comb begin
    if (pass_q || !interp) begin
      l_a_o  = l_q;
      r_a_o  = r_q;
      frac_o = '0;
    end else begin
      l_a_o  = prev_l_q;
      r_a_o  = prev_r_q;
      frac_o = frac_full[PHASE_FRAC_BITS-1:0];
    end
  end
  assign l_b_o = l_q;
  assign r_b_o = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      last_blk_q  <= 1'b0;
      cnt_q       <= '0;
      frame_idx_q <= '0;
      opos_q      <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q    <= ST_RUN;
            pass_q     <= !resample_en_i;
            last_blk_q <= (LEN_W'(frame_idx_q) + LEN_W'(1)) >= len_eff;
            cnt_q      <= '0;
          end
        end
        ST_RUN: begin
          if (step_now && !pass_q && emit) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (finish) begin
            state_q  <= ST_IDLE;
            prev_l_q <= l_q;
            prev_r_q <= r_q;
            if (pass_q || last_blk_q) begin
              frame_idx_q <= '0;
              opos_q      <= '0;
            end else begin
              frame_idx_q <= cur_q + IDX_W'(1);
              opos_q      <= emit ? POS_W'(sum_q) : pos_q;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      l_q   <= in_ch.left_sample;
      r_q   <= in_ch.right_sample;
      len_q <= len_eff;
      cur_q <= frame_idx_q;
      pos_q <= start_pos;
      sum_q <= start_sum;
    end else if (step_now && emit) begin
      pos_q <= POS_W'(sum_q);
      sum_q <= sum2;
    end
  end

endmodule

// ===== hdl/lrd_lane.sv =====
// ----------------------------------------------------------------------------
// lrd_lane
// One channel's interpolator: registered (b - a) * frac, then
// a + product scaled down with truncation toward zero.
// ----------------------------------------------------------------------------
module lrd_lane #(
  parameter int unsigned PHASE_FRAC_BITS = lrd_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  lrd_pkg::sample_t           a_i,
  input  lrd_pkg::sample_t           b_i,
  input  logic [PHASE_FRAC_BITS-1:0] frac_i,
  output lrd_pkg::sample_t           y_o
);

  localparam int unsigned DIFF_W = lrd_pkg::SAMPLE_W + 1;
  localparam int unsigned PROD_W = DIFF_W + PHASE_FRAC_BITS + 1;
  localparam int unsigned NUM_W  = PROD_W + 1;

  logic signed [DIFF_W-1:0]          diff;
  logic signed [PHASE_FRAC_BITS:0]   frac_s;
  logic signed [PROD_W-1:0]          prod_d, prod_q;
  lrd_pkg::sample_t                  a_q;
  logic signed [NUM_W-1:0]           num, adj, bias, shifted;

  assign diff   = DIFF_W'(b_i) - DIFF_W'(a_i);
  assign frac_s = $signed({1'b0, frac_i});
  assign prod_d = diff * frac_s;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      a_q    <= a_i;
    end
  end

  assign bias    = $signed({{(NUM_W - PHASE_FRAC_BITS){1'b0}}, {PHASE_FRAC_BITS{1'b1}}});
  assign num     = (NUM_W'(a_q) <<< PHASE_FRAC_BITS) + NUM_W'(prod_q);
  assign adj     = num[NUM_W-1] ? (num + bias) : num;
  assign shifted = adj >>> PHASE_FRAC_BITS;
  assign y_o     = shifted[lrd_pkg::SAMPLE_W-1:0];

endmodule

// ===== hdl/lrd_merge.sv =====
// ----------------------------------------------------------------------------
// lrd_merge
// Merge stage: averages the two lanes in stereo mode, tracks the request
// through the lane stage and holds the result in the output register.
// ----------------------------------------------------------------------------
module lrd_merge (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lrd_pkg::issue_t  issue_i,
  input  logic             stereo_i,
  input  lrd_pkg::sample_t left_i,
  input  lrd_pkg::sample_t right_i,
  output logic             adv_o,
  lrd_out_if.source        out_ch
);

  localparam int unsigned SUM_W = lrd_pkg::SAMPLE_W + 1;

  logic             s1_valid_q, s1_last_q;
  logic             out_valid_q, out_last_q;
  lrd_pkg::sample_t out_sample_q, mixed;
  logic signed [SUM_W-1:0] pair_sum, pair_adj, pair_half;

  assign adv_o = !out_valid_q || out_ch.ready;

  assign pair_sum  = SUM_W'(left_i) + SUM_W'(right_i);
  assign pair_adj  = pair_sum[SUM_W-1] ? (pair_sum + SUM_W'(1)) : pair_sum;
  assign pair_half = pair_adj >>> 1;
  assign mixed     = stereo_i ? pair_half[lrd_pkg::SAMPLE_W-1:0] : left_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      s1_valid_q  <= issue_i.valid;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s1_last_q    <= issue_i.last;
      out_last_q   <= s1_last_q;
      out_sample_q <= mixed;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.out_sample  = out_sample_q;
  assign out_ch.last_of_run = out_last_q;

endmodule

// ===== hdl/linear_resampler_downmix.sv =====
// ----------------------------------------------------------------------------
// linear_resampler_downmix
// Linear-interpolation sample-rate converter with stereo-to-mono downmix,
// built from a position sequencer, a left and a right lane and a merge stage.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                     handshake
//  in_ch     sink       left_sample, right_sample, block_length     valid/ready
//  out_ch    source     out_sample, last_of_run                     valid/ready
//  cfg       write      cfg_idx_i, cfg_data_i                       cfg_we_i
//
//  The sequencer takes a frame only while idle, then issues one output per
//  unstalled cycle, 0 to 32 of them, and takes no new frame until it is done.
//  Each output passes the lane multiply register and the output register.
//  A stalled output register holds the whole lane pipeline and the sequencer.
//  Reset clears all control state and the previous-frame samples at once.
// ----------------------------------------------------------------------------
module linear_resampler_downmix #(
  parameter int unsigned MAX_BLOCK_FRAMES = lrd_pkg::MAX_BLOCK_FRAMES_DEF,
  parameter int unsigned PHASE_FRAC_BITS  = lrd_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lrd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [lrd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  lrd_in_if.sink                          in_ch,
  lrd_out_if.source                       out_ch
);

  logic [lrd_pkg::STEP_W-1:0] phase_step_q;
  logic                       resample_en_q;
  logic                       stereo_mode_q;

  lrd_pkg::issue_t            issue;
  logic                       adv;
  lrd_pkg::sample_t           l_a, l_b, r_a, r_b, left_y, right_y;
  logic [PHASE_FRAC_BITS-1:0] frac;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q  <= lrd_pkg::STEP_RESET;
      resample_en_q <= 1'b0;
      stereo_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lrd_pkg::CFG_PHASE_STEP:  phase_step_q  <= cfg_data_i[lrd_pkg::STEP_W-1:0];
        lrd_pkg::CFG_RESAMPLE_EN: resample_en_q <= cfg_data_i[0];
        lrd_pkg::CFG_STEREO_MODE: stereo_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lrd_ctrl #(
    .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES),
    .PHASE_FRAC_BITS  (PHASE_FRAC_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .adv_i         (adv),
    .step_i        (phase_step_q),
    .resample_en_i (resample_en_q),
    .issue_o       (issue),
    .l_a_o         (l_a),
    .l_b_o         (l_b),
    .r_a_o         (r_a),
    .r_b_o         (r_b),
    .frac_o        (frac)
  );

  lrd_lane #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_lane_left (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (l_a),
    .b_i    (l_b),
    .frac_i (frac),
    .y_o    (left_y)
  );

  lrd_lane #(.PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_lane_right (
    .clk_i  (clk_i),
    .en_i   (adv),
    .a_i    (r_a),
    .b_i    (r_b),
    .frac_i (frac),
    .y_o    (right_y)
  );

  lrd_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .stereo_i (stereo_mode_q),
    .left_i   (left_y),
    .right_i  (right_y),
    .adv_o    (adv),
    .out_ch   (out_ch)
  );

  a_issue_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue.valid |-> !in_ch.ready)
    else $error("request issued while sequencer idle");

  a_issue_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue.valid |-> adv)
    else $error("request issued into stalled pipeline");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second frame taken while first still in work");

endmodule

// ===== verif/linear_resampler_downmix_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_resampler_downmix_tb
// Self-checking bench for the linear resampler with stereo downmix. A table
// of directed frames and register writes covers passthrough, downmix
// rounding, step floor, length changes mid-block and the per-frame result
// cap. Random blocks follow under several register settings. Every output
// sample is checked against an in-bench fixed-point model or typed row value.
// ----------------------------------------------------------------------------
module linear_resampler_downmix_tb;

  localparam int          ITEM_TARGET  = 130;
  localparam int          SETTLE       = 10;
  localparam int          CYCLE_LIMIT  = 600000;
  localparam int          FRAC_W       = lrd_pkg::PHASE_FRAC_BITS_DEF;
  localparam longint      STEP_FLOOR   = longint'(1) << (FRAC_W - 4);
  localparam longint      UNIT         = longint'(1) << FRAC_W;

  typedef struct {
    lrd_pkg::sample_t sample;
    logic             last;
  } mix_result_t;

  typedef enum bit {ROW_FRAME, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    lrd_pkg::cfg_idx_e reg_idx;
    int                value;
    int                left;
    int                right;
    int                len;
    bit                typed;
    int                want;
  } stim_row_t;

  localparam int N_ROWS = 35;

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,  32767, -32768,    1, 1'b1,  32767},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0, -32768,  32767,    0, 1'b1, -32768},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,   4660,     -1, 8191, 1'b1,   4660},
    '{ROW_WRITE, lrd_pkg::CFG_STEREO_MODE,       1,      0,      0,    0, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,  32767,  32767,    1, 1'b1,  32767},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0, -32768, -32768,    1, 1'b1, -32768},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0, -32768,  32767,    1, 1'b1,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,     -3,      0,    1, 1'b1,     -1},
    '{ROW_WRITE, lrd_pkg::CFG_RESAMPLE_EN,       1,      0,      0,    0, 1'b0,      0},
    '{ROW_WRITE, lrd_pkg::CFG_PHASE_STEP,     4096,      0,      0,    0, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,   1000,   3000,    1, 1'b0,      0},
    '{ROW_WRITE, lrd_pkg::CFG_STEREO_MODE,       0,      0,      0,    0, 1'b0,      0},
    '{ROW_WRITE, lrd_pkg::CFG_PHASE_STEP,        0,      0,      0,    0, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0, -32768,      5,    2, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,  32767,     -5,    2, 1'b0,      0},
    '{ROW_WRITE, lrd_pkg::CFG_PHASE_STEP,  1048576,      0,      0,    0, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,    100,      0,   20, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,    200,      0,    3, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,    300,      0,    4, 1'b0,      0},
    '{ROW_WRITE, lrd_pkg::CFG_PHASE_STEP,        1,      0,      0,    0, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,    400,      0,   20, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,    500,      0,    2, 1'b0,      0},
    '{ROW_WRITE, lrd_pkg::CFG_PHASE_STEP,    98304,      0,      0,    0, 1'b0,      0},
    '{ROW_WRITE, lrd_pkg::CFG_STEREO_MODE,       1,      0,      0,    0, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,  10000,  -9000,    4, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0, -20000,  12345,    4, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,  30000, -32768,    4, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,     -5,      7,    4, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,      7,      9,    6, 1'b0,      0},
    '{ROW_WRITE, lrd_pkg::CFG_RESAMPLE_EN,       0,      0,      0,    0, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,      8,      2,    6, 1'b1,      5},
    '{ROW_WRITE, lrd_pkg::CFG_RESAMPLE_EN,       1,      0,      0,    0, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,      9,      1,    6, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0,     11,     -1,    6, 1'b0,      0},
    '{ROW_FRAME, lrd_pkg::CFG_PHASE_STEP,        0, -32768, -32768,    7, 1'b0,      0}
  };

  logic clk_i;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [lrd_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [lrd_pkg::CFG_DATA_W-1:0] cfg_data_i;

  lrd_in_if  in_ch ();
  lrd_out_if out_ch ();

  linear_resampler_downmix uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  logic [lrd_pkg::STEP_W-1:0] step_q;
  logic                       resample_q;
  logic                       stereo_q;
  lrd_pkg::sample_t           prev_left_q;
  lrd_pkg::sample_t           prev_right_q;
  int unsigned                frame_idx_q;
  longint unsigned            out_pos_q;

  mix_result_t expected_samples [$];

  int items_sent;
  int results_checked = 0;
  int mismatches = 0;
  int settings_used;
  int burst_left;
  int cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void queue_result(ref mix_result_t q [$], input lrd_pkg::sample_t s,
                                       input logic lst);
    mix_result_t item;
    item.sample = s;
    item.last   = lst;
    q.insert(q.size(), item);
  endfunction

  function automatic lrd_pkg::sample_t downmix(input int l, input int r);
    return stereo_q ? lrd_pkg::sample_t'((l + r) / 2) : lrd_pkg::sample_t'(l);
  endfunction

  function automatic int blend(input lrd_pkg::sample_t a, input lrd_pkg::sample_t b,
                               input longint frac);
    longint num;
    num = longint'(a) * UNIT + (longint'(b) - longint'(a)) * frac;
    return int'(num / UNIT);
  endfunction

  function automatic void resample_frame(input lrd_pkg::sample_t l, input lrd_pkg::sample_t r,
                                         input logic [lrd_pkg::LEN_IN_W-1:0] len_in,
                                         output mix_result_t res [$]);
    longint unsigned len, stp, limit, cur, base, top, frac;
    int n;
    bit last_frame;
    res = {};
    n = 0;
    len = 64'(len_in);
    if (len == 0) len = 1;
    if (len > 64'(lrd_pkg::MAX_BLOCK_FRAMES_DEF)) len = 64'(lrd_pkg::MAX_BLOCK_FRAMES_DEF);
    if (!resample_q) begin
      queue_result(res, downmix(l, r), 1'b1);
      prev_left_q  = l;
      prev_right_q = r;
      frame_idx_q  = 0;
      out_pos_q    = 0;
      return;
    end
    stp = 64'(step_q);
    if (stp < STEP_FLOOR) stp = STEP_FLOOR;
    limit = len << FRAC_W;
    cur = 64'(frame_idx_q);
    last_frame = (cur + 1 >= len);
    if (cur == 0) out_pos_q = 0;
    if (cur > 0) begin
      base = (cur - 1) << FRAC_W;
      top  = cur << FRAC_W;
      while (n < lrd_pkg::OUT_CAP && out_pos_q < top && out_pos_q + stp <= limit) begin
        frac = (out_pos_q >= base) ? out_pos_q - base : 0;
        queue_result(res, downmix(blend(prev_left_q, l, longint'(frac)),
                                  blend(prev_right_q, r, longint'(frac))), 1'b0);
        n++;
        out_pos_q += stp;
      end
    end
    if (last_frame) begin
      while (n < lrd_pkg::OUT_CAP && out_pos_q + stp <= limit) begin
        queue_result(res, downmix(l, r), 1'b0);
        n++;
        out_pos_q += stp;
      end
      frame_idx_q = 0;
      out_pos_q   = 0;
    end else begin
      frame_idx_q = 32'(cur + 1);
    end
    prev_left_q  = l;
    prev_right_q = r;
    if (n > 0) res[n-1].last = 1'b1;
  endfunction

  function automatic lrd_pkg::sample_t rand_sample();
    case ($urandom_range(0, 11))
      0: return lrd_pkg::sample_t'(-32768);
      1: return lrd_pkg::sample_t'(32767);
      2: return lrd_pkg::sample_t'(-1);
      default: return lrd_pkg::sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic hold_off(input int n);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // hold requests until every expected sample is out and the block has drained
  task automatic wait_idle();
    hold_off(1);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input lrd_pkg::cfg_idx_e idx,
                           input logic [lrd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      lrd_pkg::CFG_PHASE_STEP:  step_q     = data[lrd_pkg::STEP_W-1:0];
      lrd_pkg::CFG_RESAMPLE_EN: resample_q = data[0];
      lrd_pkg::CFG_STEREO_MODE: stereo_q   = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(input lrd_pkg::sample_t l, input lrd_pkg::sample_t r,
                            input logic [lrd_pkg::LEN_IN_W-1:0] len,
                            input bit typed, input lrd_pkg::sample_t want);
    mix_result_t res [$];
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk_i);
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= l;
    in_ch.right_sample <= r;
    in_ch.block_length <= len;
    do @(posedge clk_i); while (!in_ch.ready);
    burst_left--;
    items_sent++;
    resample_frame(l, r, len, res);
    if (typed) begin
      res.delete();
      queue_result(res, want, 1'b1);
    end
    foreach (res[i]) queue_result(expected_samples, res[i].sample, res[i].last);
  endtask

  initial begin : rx_pattern
    int stall_left;
    int stall_pct;
    int pattern_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    stall_pct    = 0;
    pattern_left = 0;
    forever begin
      @(negedge clk_i);
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 8;
        endcase
      end
      pattern_left--;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 20);
      end
    end
  end

  always @(posedge clk_i) begin : out_check
    mix_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample %0d", out_ch.out_sample));
      end else begin
        want = expected_samples.pop_front();
        results_checked++;
        if (out_ch.out_sample !== want.sample)
          report_mismatch($sformatf("out_sample %0d, want %0d",
                                    out_ch.out_sample, want.sample));
        if (out_ch.last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %b, want %b",
                                    out_ch.last_of_run, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d samples outstanding", expected_samples.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned blk_len;
    int unsigned cut;
    int unsigned len_field;
    int unsigned phase_end;
    int unsigned step_val;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = lrd_pkg::CFG_PHASE_STEP;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    in_ch.block_length = '0;
    step_q             = lrd_pkg::STEP_RESET;
    resample_q         = 1'b0;
    stereo_q           = 1'b0;
    prev_left_q        = '0;
    prev_right_q       = '0;
    frame_idx_q        = 0;
    out_pos_q          = 0;
    items_sent         = 0;
    settings_used      = 1;
    burst_left         = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, lrd_pkg::CFG_DATA_W'(directed_rows[i].value));
        settings_used++;
      end else begin
        send_frame(lrd_pkg::sample_t'(directed_rows[i].left),
                   lrd_pkg::sample_t'(directed_rows[i].right),
                   lrd_pkg::LEN_IN_W'(directed_rows[i].len), directed_rows[i].typed,
                   lrd_pkg::sample_t'(directed_rows[i].want));
      end
    end

    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      case ($urandom_range(0, 9))
        6: step_val = 4096;
        7: step_val = 1048576;
        8: step_val = $urandom_range(0, 4095);
        9: step_val = $urandom_range(0, 2097151);
        default: step_val = $urandom_range(4096, 196608);
      endcase
      write_reg(lrd_pkg::CFG_PHASE_STEP, lrd_pkg::CFG_DATA_W'(step_val));
      write_reg(lrd_pkg::CFG_RESAMPLE_EN, lrd_pkg::CFG_DATA_W'($urandom_range(0, 4) != 0));
      write_reg(lrd_pkg::CFG_STEREO_MODE, lrd_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      settings_used++;
      phase_end = items_sent + $urandom_range(10, 20);
      while (items_sent < phase_end) begin
        blk_len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        // drop the tail of some blocks so the next one starts mid-block
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, blk_len) : blk_len;
        for (int k = 0; k < cut && items_sent < phase_end; k++) begin
          len_field = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : blk_len;
          send_frame(rand_sample(), rand_sample(), lrd_pkg::LEN_IN_W'(len_field), 1'b0, '0);
        end
      end
    end

    wait_idle();
    $display("sent %0d frames under %0d register settings, compared %0d output samples",
             items_sent, settings_used, results_checked);
    $display("mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
